// File: hw/rtl/bmp24_pkg.sv
package bmp24_pkg;

    localparam int DEFAULT_MAX_WIDTH  = 4096;
    localparam int DEFAULT_MAX_HEIGHT = 4096;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_PIXELS,
        PH_PAD,
        PH_DONE,
        PH_IGNORE
    } t_phase;

    typedef enum logic [3:0] {
        ERR_NONE        = 4'd0,
        ERR_SIGNATURE   = 4'd1,
        ERR_DIB_SIZE    = 4'd2,
        ERR_PLANES      = 4'd3,
        ERR_BPP         = 4'd4,
        ERR_COMPRESSION = 4'd5,
        ERR_SIZE        = 4'd6,
        ERR_OFFSET      = 4'd7,
        ERR_EARLY_END   = 4'd8
    } t_err;

    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        is_error;
        t_err        error_code;
        logic        last_pixel;
        logic [12:0] image_width;
        logic [12:0] image_height;
    } t_result;

endpackage

// File: hw/rtl/bmp24_core.sv
module bmp24_core #(
    parameter int MAX_WIDTH  = bmp24_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = bmp24_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_byte,
    input  logic               i_eof,
    output logic               o_res_valid,
    output bmp24_pkg::t_result o_res
);

    localparam int FW = $clog2(MAX_WIDTH + 1);
    localparam int FH = $clog2(MAX_HEIGHT + 1);

    localparam logic [31:0] POS_SIG         = 32'd1;
    localparam logic [31:0] POS_OFFSET      = 32'd13;
    localparam logic [31:0] POS_DIB         = 32'd17;
    localparam logic [31:0] POS_WIDTH       = 32'd21;
    localparam logic [31:0] POS_HEIGHT      = 32'd25;
    localparam logic [31:0] POS_PLANES      = 32'd27;
    localparam logic [31:0] POS_BPP         = 32'd29;
    localparam logic [31:0] POS_COMPRESSION = 32'd33;
    localparam logic [31:0] POS_LAST        = 32'd53;
    localparam logic [31:0] HEADER_BYTES    = 32'd54;
    localparam logic [15:0] SIGNATURE       = 16'h4D42;
    localparam logic [31:0] MIN_DIB         = 32'd40;
    localparam logic [15:0] BPP_24          = 16'd24;
    localparam logic [31:0] MAX_W32         = 32'(MAX_WIDTH);
    localparam logic [31:0] MAX_H32         = 32'(MAX_HEIGHT);

    bmp24_pkg::t_phase r_phase, n_phase;
    logic [31:0]       r_pos, n_pos;
    logic [31:0]       r_shift, n_shift;
    logic [31:0]       r_dstart, n_dstart;
    logic [31:0]       r_raw_w, n_raw_w;
    logic [31:0]       r_raw_h, n_raw_h;
    logic [15:0]       r_planes, n_planes;
    logic [15:0]       r_bpp, n_bpp;
    logic [31:0]       r_compr, n_compr;
    logic [FW-1:0]     r_fw, n_fw;
    logic [FH-1:0]     r_fh, n_fh;
    logic              r_top, n_top;
    logic [FW-1:0]     r_col, n_col;
    logic [FH-1:0]     r_row, n_row;
    logic [1:0]        r_comp, n_comp;
    logic [7:0]        r_blue, n_blue;
    logic [7:0]        r_green, n_green;
    logic [1:0]        r_pad, n_pad;

    bmp24_pkg::t_err   code;
    logic              pix;
    logic [31:0]       hdr_shift;
    logic [31:0]       pos_inc;
    logic [31:0]       height_mag;
    logic [FW-1:0]     col_inc;
    logic [FH-1:0]     row_inc;
    logic [FH-1:0]     py;
    logic [31:0]       fw32;
    logic [31:0]       fh32;
    logic [31:0]       col32;
    logic [31:0]       py32;

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_shift    = r_shift;
        n_dstart   = r_dstart;
        n_raw_w    = r_raw_w;
        n_raw_h    = r_raw_h;
        n_planes   = r_planes;
        n_bpp      = r_bpp;
        n_compr    = r_compr;
        n_fw       = r_fw;
        n_fh       = r_fh;
        n_top      = r_top;
        n_col      = r_col;
        n_row      = r_row;
        n_comp     = r_comp;
        n_blue     = r_blue;
        n_green    = r_green;
        n_pad      = r_pad;
        code       = bmp24_pkg::ERR_NONE;
        pix        = 1'b0;
        hdr_shift  = {i_byte, r_shift[31:8]};
        pos_inc    = r_pos + 32'd1;
        height_mag = r_raw_h[31] ? (32'd0 - r_raw_h) : r_raw_h;
        col_inc    = r_col + FW'(1);
        row_inc    = r_row + FH'(1);
        py         = r_top ? r_row : (r_fh - FH'(1) - r_row);
        fw32       = 32'(r_fw);
        fh32       = 32'(r_fh);
        col32      = 32'(r_col);
        py32       = 32'(py);

        case (r_phase)
            bmp24_pkg::PH_HEADER: begin
                n_shift = hdr_shift;
                n_pos   = pos_inc;
                if (r_pos == POS_SIG) begin
                    if (hdr_shift[31:16] != SIGNATURE) begin
                        code = bmp24_pkg::ERR_SIGNATURE;
                    end
                end else if (r_pos == POS_OFFSET) begin
                    n_dstart = hdr_shift;
                end else if (r_pos == POS_DIB) begin
                    if (hdr_shift < MIN_DIB) begin
                        code = bmp24_pkg::ERR_DIB_SIZE;
                    end
                end else if (r_pos == POS_WIDTH) begin
                    n_raw_w = hdr_shift;
                end else if (r_pos == POS_HEIGHT) begin
                    n_raw_h = hdr_shift;
                end else if (r_pos == POS_PLANES) begin
                    n_planes = hdr_shift[31:16];
                end else if (r_pos == POS_BPP) begin
                    n_bpp = hdr_shift[31:16];
                end else if (r_pos == POS_COMPRESSION) begin
                    n_compr = hdr_shift;
                end else if (r_pos == POS_LAST) begin
                    if (r_planes != 16'd1) begin
                        code = bmp24_pkg::ERR_PLANES;
                    end else if (r_bpp != BPP_24) begin
                        code = bmp24_pkg::ERR_BPP;
                    end else if (r_compr != 32'd0) begin
                        code = bmp24_pkg::ERR_COMPRESSION;
                    end else if (r_raw_w == 32'd0 || r_raw_w[31] || r_raw_w > MAX_W32) begin
                        code = bmp24_pkg::ERR_SIZE;
                    end else if (height_mag == 32'd0 || height_mag > MAX_H32) begin
                        code = bmp24_pkg::ERR_SIZE;
                    end else if (r_dstart < HEADER_BYTES) begin
                        code = bmp24_pkg::ERR_OFFSET;
                    end else begin
                        n_fw    = r_raw_w[FW-1:0];
                        n_fh    = height_mag[FH-1:0];
                        n_top   = r_raw_h[31];
                        n_phase = (r_dstart == HEADER_BYTES) ? bmp24_pkg::PH_PIXELS
                                                             : bmp24_pkg::PH_SKIP;
                    end
                end
            end
            bmp24_pkg::PH_SKIP: begin
                n_pos = pos_inc;
                if (pos_inc >= r_dstart) begin
                    n_phase = bmp24_pkg::PH_PIXELS;
                end
            end
            bmp24_pkg::PH_PIXELS: begin
                case (r_comp)
                    2'd0: begin
                        n_blue = i_byte;
                        n_comp = 2'd1;
                    end
                    2'd1: begin
                        n_green = i_byte;
                        n_comp  = 2'd2;
                    end
                    default: begin
                        n_comp = 2'd0;
                        pix    = 1'b1;
                        n_col  = col_inc;
                        if (col_inc == r_fw) begin
                            n_col = '0;
                            n_pad = fw32[1:0];
                            if (fw32[1:0] != 2'd0) begin
                                n_phase = bmp24_pkg::PH_PAD;
                            end else begin
                                n_row   = row_inc;
                                n_phase = (row_inc >= r_fh) ? bmp24_pkg::PH_DONE
                                                            : bmp24_pkg::PH_PIXELS;
                            end
                        end
                    end
                endcase
            end
            bmp24_pkg::PH_PAD: begin
                n_pad = r_pad - 2'd1;
                if (r_pad == 2'd1) begin
                    n_row   = row_inc;
                    n_phase = (row_inc >= r_fh) ? bmp24_pkg::PH_DONE
                                                : bmp24_pkg::PH_PIXELS;
                end
            end
            default: begin
            end
        endcase

        if (code != bmp24_pkg::ERR_NONE) begin
            n_phase = bmp24_pkg::PH_IGNORE;
        end
        if (i_eof) begin
            if (code == bmp24_pkg::ERR_NONE && n_phase != bmp24_pkg::PH_DONE &&
                n_phase != bmp24_pkg::PH_IGNORE) begin
                code = bmp24_pkg::ERR_EARLY_END;
            end
            n_phase = bmp24_pkg::PH_HEADER;
            n_pos   = '0;
            n_col   = '0;
            n_row   = '0;
            n_comp  = '0;
            n_pad   = '0;
        end

        o_res       = '0;
        o_res_valid = i_valid && (pix || code != bmp24_pkg::ERR_NONE);
        if (code != bmp24_pkg::ERR_NONE) begin
            o_res.is_error   = 1'b1;
            o_res.error_code = code;
        end else begin
            o_res.pixel_x      = col32[11:0];
            o_res.pixel_y      = py32[11:0];
            o_res.red          = i_byte;
            o_res.green        = r_green;
            o_res.blue         = r_blue;
            o_res.error_code   = bmp24_pkg::ERR_NONE;
            o_res.last_pixel   = (row_inc == r_fh) && (col_inc == r_fw);
            o_res.image_width  = fw32[12:0];
            o_res.image_height = fh32[12:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= bmp24_pkg::PH_HEADER;
            r_pos   <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_comp  <= '0;
            r_pad   <= '0;
        end else if (i_valid) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_col   <= n_col;
            r_row   <= n_row;
            r_comp  <= n_comp;
            r_pad   <= n_pad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_shift  <= n_shift;
            r_dstart <= n_dstart;
            r_raw_w  <= n_raw_w;
            r_raw_h  <= n_raw_h;
            r_planes <= n_planes;
            r_bpp    <= n_bpp;
            r_compr  <= n_compr;
            r_fw     <= n_fw;
            r_fh     <= n_fh;
            r_top    <= n_top;
            r_blue   <= n_blue;
            r_green  <= n_green;
        end
    end

    a_eof_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_eof |=> r_phase == bmp24_pkg::PH_HEADER && r_pos == 32'd0)
        else $error("End of file did not restart header parsing.");

    a_error_has_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.is_error |-> o_res.error_code != bmp24_pkg::ERR_NONE)
        else $error("Error result carries no error code.");

    a_column_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == bmp24_pkg::PH_PIXELS |-> r_col < r_fw)
        else $error("Column counter ran past the image width.");

    a_component_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_comp != 2'd3)
        else $error("Color component index out of range.");

    a_pad_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == bmp24_pkg::PH_PAD |-> r_pad != 2'd0)
        else $error("Row padding phase entered with no bytes to skip.");

endmodule

// File: hw/rtl/bmp24_stream_decoder.sv
// A pixel or error result is registered and appears on the master side in the
// cycle after the byte transaction that causes it.
// One byte per cycle unless the master side stalls; the output register lets a
// new byte be taken in the same cycle that a pending result is handed off.
// Reset (synchronous, active low) returns the parser to the header phase and
// empties the output register.
module bmp24_stream_decoder #(
    parameter int MAX_WIDTH  = bmp24_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = bmp24_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // data_byte
    input  logic        i_s_axis_tlast,   // end_of_file
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // pixel_x, pixel_y, red, green, blue, error_code, image_width, image_height
    output logic [79:0] o_m_axis_tdata,
    output logic        o_m_axis_tuser,   // is_error
    output logic        o_m_axis_tlast    // last_pixel
);

    logic               accept;
    logic               res_valid;
    bmp24_pkg::t_result res;
    logic               r_out_valid;
    bmp24_pkg::t_result r_out;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    bmp24_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_byte      (i_s_axis_tdata),
        .i_eof       (i_s_axis_tlast),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && o_s_axis_tready) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.is_error;
    assign o_m_axis_tlast  = r_out.last_pixel;
    assign o_m_axis_tdata  = {2'b00, r_out.image_height, r_out.image_width,
                              4'(r_out.error_code), r_out.blue, r_out.green,
                              r_out.red, r_out.pixel_y, r_out.pixel_x};

endmodule

// File: bench/tb_bmp24_stream_decoder.sv
`timescale 1ns / 1ps

module tb_bmp24_stream_decoder;

    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int unsigned ITEM_COUNT = 900;

    typedef struct packed {
        logic [7:0] data;
        logic       eof;
    } t_file_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    t_file_byte          pending_bytes[$];
    logic [7:0]          file_bytes[$];
    bmp24_pkg::t_result  expected_results[$];

    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int          send_hold = 0;
    int          ready_hold = 0;
    logic        quiet_mode = 1'b0;
    bmp24_pkg::t_result want;
    bmp24_pkg::t_result got;

    bmp24_pkg::t_phase phase;
    int unsigned byte_pos;
    int unsigned hdr_shift;
    int unsigned data_start;
    int unsigned dib_len;
    int unsigned raw_w;
    int unsigned raw_h;
    int unsigned hdr_planes;
    int unsigned hdr_bpp;
    int unsigned hdr_compression;
    int unsigned frame_w;
    int unsigned frame_h;
    logic        direct_rows;
    int unsigned col;
    int unsigned row;
    int unsigned comp_idx;
    int unsigned pad_left;
    logic [7:0]  held_b;
    logic [7:0]  held_g;

    bmp24_stream_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 999);
        if (r < 4) quiet_mode = !quiet_mode;
        if (quiet_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void restart_file();
        phase = bmp24_pkg::PH_HEADER;
        byte_pos = 0;
        hdr_shift = 0;
        data_start = 0;
        dib_len = 0;
        raw_w = 0;
        raw_h = 0;
        hdr_planes = 0;
        hdr_bpp = 0;
        hdr_compression = 0;
        frame_w = 0;
        frame_h = 0;
        direct_rows = 1'b0;
        col = 0;
        row = 0;
        comp_idx = 0;
        pad_left = 0;
        held_b = 8'd0;
        held_g = 8'd0;
    endfunction

    function automatic void close_row();
        row++;
        phase = (row >= frame_h) ? bmp24_pkg::PH_DONE : bmp24_pkg::PH_PIXELS;
    endfunction

    // Advances the decoder state by one byte and queues the result it causes.
    function automatic void decode_byte(input logic [7:0] b, input logic eof);
        bmp24_pkg::t_err    code;
        bmp24_pkg::t_result res;
        logic               pixel_out;
        int unsigned        mag;
        code = bmp24_pkg::ERR_NONE;
        pixel_out = 1'b0;
        res = '0;
        case (phase)
            bmp24_pkg::PH_HEADER: begin
                hdr_shift = {b, hdr_shift[31:8]};
                if (byte_pos == 1 && hdr_shift[31:16] != 16'h4D42) begin
                    code = bmp24_pkg::ERR_SIGNATURE;
                end else begin
                    if (byte_pos == 13) data_start = hdr_shift;
                    if (byte_pos == 17) begin
                        dib_len = hdr_shift;
                        if (dib_len < 40) code = bmp24_pkg::ERR_DIB_SIZE;
                    end
                    if (byte_pos == 21) raw_w = hdr_shift;
                    if (byte_pos == 25) raw_h = hdr_shift;
                    if (byte_pos == 27) hdr_planes = hdr_shift >> 16;
                    if (byte_pos == 29) hdr_bpp = hdr_shift >> 16;
                    if (byte_pos == 33) hdr_compression = hdr_shift;
                    if (byte_pos == 53) begin
                        mag = raw_h[31] ? (32'd0 - raw_h) : raw_h;
                        if (hdr_planes != 1) begin
                            code = bmp24_pkg::ERR_PLANES;
                        end else if (hdr_bpp != 24) begin
                            code = bmp24_pkg::ERR_BPP;
                        end else if (hdr_compression != 0) begin
                            code = bmp24_pkg::ERR_COMPRESSION;
                        end else if (raw_w == 0 || raw_w[31] ||
                                     raw_w > bmp24_pkg::DEFAULT_MAX_WIDTH) begin
                            code = bmp24_pkg::ERR_SIZE;
                        end else if (mag == 0 || mag > bmp24_pkg::DEFAULT_MAX_HEIGHT) begin
                            code = bmp24_pkg::ERR_SIZE;
                        end else if (data_start < 54) begin
                            code = bmp24_pkg::ERR_OFFSET;
                        end else begin
                            frame_w = raw_w;
                            frame_h = mag;
                            direct_rows = raw_h[31];
                            phase = (data_start == 54) ? bmp24_pkg::PH_PIXELS
                                                       : bmp24_pkg::PH_SKIP;
                        end
                    end
                end
                byte_pos++;
            end
            bmp24_pkg::PH_SKIP: begin
                byte_pos++;
                if (byte_pos >= data_start) phase = bmp24_pkg::PH_PIXELS;
            end
            bmp24_pkg::PH_PIXELS: begin
                if (comp_idx == 0) begin
                    held_b = b;
                    comp_idx = 1;
                end else if (comp_idx == 1) begin
                    held_g = b;
                    comp_idx = 2;
                end else begin
                    comp_idx = 0;
                    pixel_out = 1'b1;
                    res.pixel_x = col[11:0];
                    res.pixel_y = direct_rows ? row[11:0] : 12'(frame_h - 1 - row);
                    res.red = b;
                    res.green = held_g;
                    res.blue = held_b;
                    res.last_pixel = (row + 1 == frame_h) && (col + 1 == frame_w);
                    res.image_width = frame_w[12:0];
                    res.image_height = frame_h[12:0];
                    col++;
                    if (col >= frame_w) begin
                        col = 0;
                        pad_left = frame_w & 3;
                        if (pad_left != 0) phase = bmp24_pkg::PH_PAD;
                        else close_row();
                    end
                end
            end
            bmp24_pkg::PH_PAD: begin
                pad_left = (pad_left - 1) & 3;
                if (pad_left == 0) close_row();
            end
            default: begin
            end
        endcase
        if (code != bmp24_pkg::ERR_NONE) phase = bmp24_pkg::PH_IGNORE;
        if (eof) begin
            if (code == bmp24_pkg::ERR_NONE && phase != bmp24_pkg::PH_DONE &&
                phase != bmp24_pkg::PH_IGNORE) code = bmp24_pkg::ERR_EARLY_END;
            restart_file();
        end
        if (code != bmp24_pkg::ERR_NONE) begin
            res = '0;
            res.is_error = 1'b1;
            res.error_code = code;
            expected_results.push_back(res);
        end else if (pixel_out) begin
            expected_results.push_back(res);
        end
    endfunction

    function automatic void check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            mismatches++;
        end
    endfunction

    task automatic put_le(input int unsigned v, input int n);
        for (int i = 0; i < n; i++) file_bytes.push_back(8'(v >> (8 * i)));
    endtask

    task automatic start_file(input logic [15:0] sig, input int unsigned offset,
                              input int unsigned dib, input int unsigned width,
                              input int unsigned height, input logic [15:0] n_planes,
                              input logic [15:0] n_bpp, input int unsigned comp);
        file_bytes.delete();
        put_le(sig, 2);
        put_le($urandom, 4);
        put_le($urandom, 4);
        put_le(offset, 4);
        put_le(dib, 4);
        put_le(width, 4);
        put_le(height, 4);
        put_le(n_planes, 2);
        put_le(n_bpp, 2);
        put_le(comp, 4);
        repeat (20) file_bytes.push_back(8'($urandom));
        for (int unsigned i = 54; i < offset; i++) file_bytes.push_back(8'($urandom));
    endtask

    // A negative cut truncates the file at a random point.
    task automatic queue_file(input int cut);
        int n;
        n = file_bytes.size();
        if (cut < 0) cut = $urandom_range(1, n);
        if (cut > 0 && cut < n) n = cut;
        for (int i = 0; i < n; i++) pending_bytes.push_back('{file_bytes[i], i == n - 1});
    endtask

    task automatic good_image(input int unsigned w, input int unsigned rows,
                              input logic flip, input int unsigned skip,
                              input int unsigned dib_extra, input int unsigned trail,
                              input int cut);
        start_file(16'h4D42, 54 + dib_extra + skip, 40 + dib_extra, w,
                   flip ? (32'd0 - rows) : rows, 16'd1, 16'd24, 0);
        for (int unsigned r = 0; r < rows; r++) begin
            repeat (3 * w + (w & 3)) file_bytes.push_back(8'($urandom));
        end
        repeat (trail) file_bytes.push_back(8'($urandom));
        queue_file(cut);
    endtask

    task automatic bad_header(input logic [15:0] sig, input int unsigned dib,
                              input logic [15:0] n_planes, input logic [15:0] n_bpp,
                              input int unsigned comp, input int unsigned width,
                              input int unsigned height, input int unsigned offset,
                              input int cut);
        start_file(sig, offset, dib, width, height, n_planes, n_bpp, comp);
        repeat (5) file_bytes.push_back(8'($urandom));
        queue_file(cut);
    endtask

    task automatic random_bad_header();
        logic [15:0] sig;
        logic [15:0] n_planes;
        logic [15:0] n_bpp;
        int unsigned dib;
        int unsigned comp;
        int unsigned width;
        int unsigned height;
        int unsigned offset;
        sig = 16'h4D42;
        dib = 40;
        n_planes = 16'd1;
        n_bpp = 16'd24;
        comp = 0;
        width = $urandom_range(1, 6);
        height = $urandom_range(1, 4);
        offset = 54;
        case ($urandom_range(0, 7))
            0: sig = sig ^ 16'($urandom_range(1, 65535));
            1: dib = $urandom_range(0, 39);
            2: n_planes = 16'd1 ^ 16'($urandom_range(1, 65535));
            3: n_bpp = 16'd24 ^ 16'($urandom_range(1, 65535));
            4: comp = $urandom | 32'd1;
            5: width = ($urandom_range(0, 1) == 0) ? 0 : ($urandom | 32'h8000_0000);
            6: height = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(4097, 70000);
            default: offset = $urandom_range(0, 53);
        endcase
        bad_header(sig, dib, n_planes, n_bpp, comp, width, height, offset,
                   ($urandom_range(0, 4) == 0) ? -1 : 0);
    endtask

    // Byte source: holds each transaction until it is taken, then waits a random gap.
    always @(posedge i_clk) begin
        t_file_byte nxt;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (send_hold > 0) begin
                    send_hold--;
                    s_tvalid <= 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    nxt = pending_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= nxt.data;
                    s_tlast <= nxt.eof;
                    send_hold = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result sink: compares each transaction with the oldest expected pixel or error.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.pixel_x = m_tdata[11:0];
                got.pixel_y = m_tdata[23:12];
                got.red = m_tdata[31:24];
                got.green = m_tdata[39:32];
                got.blue = m_tdata[47:40];
                got.error_code = bmp24_pkg::t_err'(m_tdata[51:48]);
                got.image_width = m_tdata[64:52];
                got.image_height = m_tdata[77:65];
                got.is_error = m_tuser;
                got.last_pixel = m_tlast;
                if (expected_results.size() == 0) begin
                    $error("result with none expected: tdata %h tuser %b tlast %b",
                           m_tdata, m_tuser, m_tlast);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("pixel_x", want.pixel_x, got.pixel_x);
                    check_field("pixel_y", want.pixel_y, got.pixel_y);
                    check_field("red", want.red, got.red);
                    check_field("green", want.green, got.green);
                    check_field("blue", want.blue, got.blue);
                    check_field("is_error", want.is_error, got.is_error);
                    check_field("error_code", want.error_code, got.error_code);
                    check_field("last_pixel", want.last_pixel, got.last_pixel);
                    check_field("image_width", want.image_width, got.image_width);
                    check_field("image_height", want.image_height, got.image_height);
                end
            end
            if (ready_hold > 0) begin
                ready_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (m_tvalid && m_tready) ready_hold = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("bmp24_stream_decoder: mismatch");
            $finish;
        end
    end

    initial begin
        int unsigned w;
        int unsigned rows;
        int          pick;
        restart_file();

        good_image(2, 2, 1'b0, 0, 0, 0, 0);
        good_image(3, 2, 1'b1, 6, 0, 0, 0);
        good_image(4, 1, 1'b0, 3, 16, 5, 0);
        bad_header(16'h4E42, 40, 16'd1, 16'd24, 0, 2, 2, 54, 2);
        bad_header(16'h4D42, 39, 16'd1, 16'd24, 0, 2, 2, 54, 18);
        bad_header(16'h4D42, 40, 16'd2, 16'd24, 0, 2, 2, 54, 54);
        bad_header(16'h4D42, 40, 16'd1, 16'd32, 0, 2, 2, 54, 54);
        bad_header(16'h4D42, 40, 16'd1, 16'd24, 1, 2, 2, 54, 54);
        bad_header(16'h4D42, 40, 16'd1, 16'd24, 0, 4097, 2, 54, 54);
        bad_header(16'h4D42, 40, 16'd1, 16'd24, 0, 2, 32'h8000_0000, 54, 0);
        bad_header(16'h4D42, 40, 16'd1, 16'd24, 0, 2, 2, 53, 0);
        good_image(2, 2, 1'b0, 0, 0, 0, 1);
        good_image(2, 2, 1'b0, 8, 0, 0, 58);
        good_image(2, 2, 1'b0, 0, 0, 0, 68);
        good_image(4096, 1, 1'b1, 0, 0, 0, 60);
        good_image(1, 4096, 1'b0, 0, 0, 2, 70);

        while (pending_bytes.size() < ITEM_COUNT) begin
            pick = $urandom_range(0, 99);
            w = $urandom_range(1, 6);
            rows = $urandom_range(1, 4);
            if (pick < 70) begin
                good_image(w, rows, 1'($urandom_range(0, 1)),
                           ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6),
                           ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12),
                           ($urandom_range(0, 9) < 3) ? $urandom_range(1, 4) : 0,
                           ($urandom_range(0, 99) < 15) ? -1 : 0);
            end else if (pick < 90) begin
                random_bad_header();
            end else begin
                file_bytes.delete();
                repeat ($urandom_range(1, 40)) file_bytes.push_back(8'($urandom));
                queue_file(0);
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || s_tvalid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("bmp24_stream_decoder: match");
        end else begin
            $display("bmp24_stream_decoder: mismatch");
        end
        $finish;
    end

endmodule

// File: bmp24_stream_decoder.f
hw/rtl/bmp24_pkg.sv
hw/rtl/bmp24_core.sv
hw/rtl/bmp24_stream_decoder.sv
bench/tb_bmp24_stream_decoder.sv
